// File: rtl/chm_pkg.sv
// Package: types, constants and state codes for the chained hash map.
package chm_pkg;

  localparam int BUCKETS    = 16;
  localparam int NODES      = 256;
  localparam int VALUE_BITS = 64;

  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int NODE_W = $clog2(NODES);
  localparam int PTR_W  = NODE_W + 1;
  localparam int CNT_W  = NODE_W + 1;

  localparam logic [PTR_W-1:0] EMPTY_MARK = PTR_W'(NODES);

  typedef enum logic [1:0] {
    MODE_PUT    = 2'd0,
    MODE_GET    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [30:0] key;
    logic [63:0] value_in;
  } in_beat_t;

  typedef struct packed {
    logic        found;
    logic [63:0] value_out;
    logic [1:0]  status;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_HEAD,
    S_READ,
    S_CMP,
    S_PUT_NEW,
    S_PUT_LINK,
    S_REM_NEXT,
    S_REM_FREE,
    S_GET_VAL,
    S_DONE
  } state_t;

endpackage

// File: rtl/chained_hash_map.sv
// Top level: chained hash map with node pool held in memories and a walk sequencer.
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    chm_pkg::in_beat_t
//   out      out  out_valid/out_ready  chm_pkg::out_beat_t
//
// An operation runs IDLE, HEAD, READ, one CMP per chain node compared, then DONE; the
// read of the next node overlaps each compare. A miss adds PUT_NEW, a new node adds
// PUT_LINK, an unlink REM_FREE; an empty bucket skips READ; mode three skips to DONE.
// After reset a pass over every node builds the free list; in_ready stays low.
// in_ready is high only in idle; the result sits in an output register until taken.
module chained_hash_map (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  chm_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output chm_pkg::out_beat_t  out_data
);

  localparam int NW = chm_pkg::NODE_W;
  localparam int PW = chm_pkg::PTR_W;
  localparam int BW = chm_pkg::BKT_W;
  localparam int VB = chm_pkg::VALUE_BITS;

  chm_pkg::state_t state, state_next;

  logic [PW-1:0] bucket_head [chm_pkg::BUCKETS];
  logic [chm_pkg::BUCKETS-1:0] head_set;

  logic [30:0]   node_key   [chm_pkg::NODES];
  logic [VB-1:0] node_value [chm_pkg::NODES];
  logic [PW-1:0] node_next  [chm_pkg::NODES];

  logic [PW-1:0] free_head;
  logic [chm_pkg::CNT_W-1:0] entry_count;
  logic [NW:0]   init_cnt;

  logic [1:0]    op_mode;
  logic [30:0]   op_key;
  logic [VB-1:0] op_val;
  logic [BW-1:0] op_bkt;
  logic [PW-1:0] cur, prev;
  logic [NW:0]   steps;

  logic [30:0]   rd_key;
  logic [PW-1:0] rd_next;
  logic [VB-1:0] rd_val;
  logic [PW-1:0] hd;

  chm_pkg::out_beat_t res;

  assign hd = head_set[op_bkt] ? bucket_head[op_bkt] : chm_pkg::EMPTY_MARK;

  // node memory write and read ports
  logic          nk_we, nv_we, nn_we;
  logic [NW-1:0] nk_a, nv_a, nn_a;
  logic [PW-1:0] nn_d;
  logic [NW-1:0] rd_a;

  always_ff @(posedge clk) begin
    if (nk_we) node_key[nk_a] <= op_key;
    if (nv_we) node_value[nv_a] <= op_val;
    if (nn_we) node_next[nn_a] <= nn_d;
    rd_key  <= node_key[rd_a];
    rd_next <= node_next[rd_a];
    rd_val  <= node_value[rd_a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chm_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    nk_we = 1'b0;
    nv_we = 1'b0;
    nn_we = 1'b0;
    nk_a  = cur[NW-1:0];
    nv_a  = cur[NW-1:0];
    nn_a  = cur[NW-1:0];
    nn_d  = rd_next;
    rd_a  = cur[NW-1:0];
    unique case (state)
      chm_pkg::S_INIT: begin
        nn_we = 1'b1;
        nn_a  = init_cnt[NW-1:0];
        nn_d  = PW'(init_cnt) + PW'(1);
        if (init_cnt == (NW+1)'(chm_pkg::NODES - 1)) state_next = chm_pkg::S_IDLE;
      end
      chm_pkg::S_IDLE: if (in_valid) state_next = chm_pkg::S_HEAD;
      chm_pkg::S_HEAD: begin
        if (op_mode == chm_pkg::MODE_NOP) state_next = chm_pkg::S_DONE;
        else if (hd == chm_pkg::EMPTY_MARK) state_next = chm_pkg::S_PUT_NEW;
        else state_next = chm_pkg::S_READ;
      end
      chm_pkg::S_READ: state_next = chm_pkg::S_CMP;
      chm_pkg::S_CMP: begin
        if (rd_key == op_key) begin
          unique case (op_mode)
            chm_pkg::MODE_PUT: begin
              nv_we = 1'b1;
              state_next = chm_pkg::S_DONE;
            end
            chm_pkg::MODE_GET: state_next = chm_pkg::S_DONE;
            default: begin
              if (prev != chm_pkg::EMPTY_MARK) begin
                nn_we = 1'b1;
                nn_a  = prev[NW-1:0];
                nn_d  = rd_next;
              end
              state_next = chm_pkg::S_REM_FREE;
            end
          endcase
        end else if (rd_next == chm_pkg::EMPTY_MARK ||
                     steps == (NW+1)'(chm_pkg::NODES - 1)) begin
          state_next = chm_pkg::S_PUT_NEW;
        end else begin
          rd_a = rd_next[NW-1:0];
          state_next = chm_pkg::S_CMP;
        end
      end
      chm_pkg::S_PUT_NEW: begin
        rd_a = free_head[NW-1:0];
        if (op_mode == chm_pkg::MODE_PUT && free_head != chm_pkg::EMPTY_MARK)
          state_next = chm_pkg::S_PUT_LINK;
        else state_next = chm_pkg::S_DONE;
      end
      chm_pkg::S_PUT_LINK: begin
        nk_we = 1'b1;
        nv_we = 1'b1;
        nn_we = 1'b1;
        nn_d  = hd;
        state_next = chm_pkg::S_DONE;
      end
      chm_pkg::S_REM_FREE: begin
        nn_we = 1'b1;
        nn_d  = free_head;
        state_next = chm_pkg::S_DONE;
      end
      chm_pkg::S_REM_NEXT, chm_pkg::S_GET_VAL: state_next = chm_pkg::S_DONE;
      chm_pkg::S_DONE: if (out_ready) state_next = chm_pkg::S_IDLE;
      default: state_next = chm_pkg::S_IDLE;
    endcase
  end

  // rd_a in S_READ reads cur; in S_CMP miss it prefetches the next node.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt    <= '0;
      head_set    <= '0;
      free_head   <= '0;
      entry_count <= '0;
    end else begin
      unique case (state)
        chm_pkg::S_INIT: init_cnt <= init_cnt + 1'b1;
        chm_pkg::S_IDLE: begin
          if (in_valid) begin
            op_mode <= in_data.mode;
            op_key  <= in_data.key;
            op_val  <= in_data.value_in[VB-1:0];
            op_bkt  <= in_data.key[BW-1:0];
            res     <= '{found: 1'b0, value_out: '0, status: chm_pkg::ST_NOT_FOUND};
          end
        end
        chm_pkg::S_HEAD: begin
          cur   <= hd;
          prev  <= chm_pkg::EMPTY_MARK;
          steps <= '0;
        end
        chm_pkg::S_CMP: begin
          if (rd_key == op_key) begin
            res.found  <= 1'b1;
            res.status <= chm_pkg::ST_OK;
            if (op_mode == chm_pkg::MODE_GET) res.value_out <= 64'(rd_val);
            if (op_mode == chm_pkg::MODE_REMOVE) begin
              if (prev == chm_pkg::EMPTY_MARK) begin
                bucket_head[op_bkt] <= rd_next;
                head_set[op_bkt]    <= 1'b1;
              end
              if (entry_count != '0) entry_count <= entry_count - 1'b1;
            end
          end else begin
            prev  <= cur;
            cur   <= rd_next;
            steps <= steps + 1'b1;
          end
        end
        chm_pkg::S_PUT_NEW: begin
          cur <= free_head;
          if (op_mode == chm_pkg::MODE_PUT) begin
            res.status <= (free_head == chm_pkg::EMPTY_MARK) ?
                          chm_pkg::ST_FULL : chm_pkg::ST_OK;
          end
        end
        chm_pkg::S_PUT_LINK: begin
          free_head           <= rd_next;
          bucket_head[op_bkt] <= cur;
          head_set[op_bkt]    <= 1'b1;
          entry_count         <= entry_count + 1'b1;
        end
        chm_pkg::S_REM_FREE: free_head <= cur;
        default: ;
      endcase
    end
  end

  assign in_ready  = (state == chm_pkg::S_IDLE);
  assign out_valid = (state == chm_pkg::S_DONE);
  assign out_data  = res;

endmodule

// File: rtl/chm_checker.sv
// Checker: port-level properties of the chained hash map, bound to the top level.
module chm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input chm_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input chm_pkg::out_beat_t out_data
);

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in_ready with result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= chm_pkg::ST_FULL) else $error("bad status");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |-> out_data.status == chm_pkg::ST_OK)
    else $error("found without ok");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("took two beats");

endmodule

bind chained_hash_map chm_checker u_chm_checker (.*);
